// ----- rtl/fwg_pkg.sv -----
// shared types, codes and constants of the fourier waveform generator
// no dependencies; imported by every module of the block but fwg_mul
package fwg_pkg;

	localparam int BUFFER_LEN = 65536;

	localparam int TERM_FRAC = 23;
	localparam int SINE_FRAC = 15;
	localparam int COEF_FRAC = 30;

	localparam logic [31:0] COEF_INV_PI = 32'd341782638;
	localparam logic [31:0] COEF_FOUR_PI = 32'd1367130551;
	localparam logic [31:0] COEF_INV_PI2 = 32'd108792793;
	localparam int Q23_HALF = 4194304;

	localparam logic [14:0] AMPLITUDE_RESET = 15'd16384;
	localparam logic [6:0] HARMONIC_RESET = 7'd16;

	localparam longint unsigned SINC1 = 64'd1686629713;
	localparam longint unsigned SINC3 = 64'd693598668;
	localparam longint unsigned SINC5 = 64'd85569306;
	localparam longint unsigned SINC7 = 64'd5026995;
	localparam longint unsigned SINC9 = 64'd172272;

	typedef enum logic [1:0] {
		MODE_SINE     = 2'd0,
		MODE_SAW      = 2'd1,
		MODE_SQUARE   = 2'd2,
		MODE_TRIANGLE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_WAVE_MODE      = 3'd0,
		REG_AMPLITUDE      = 3'd1,
		REG_PHASE_STEP     = 3'd2,
		REG_HARMONIC_COUNT = 3'd3,
		REG_PHASE_OFFSET   = 3'd4
	} reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PHASE,
		ST_SETUP,
		ST_ROM,
		ST_TERM,
		ST_ACC,
		ST_COEF,
		ST_SCALE,
		ST_AMP,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_PHASE,
		MUL_TERM,
		MUL_COEF,
		MUL_AMP
	} mul_op_t;

	typedef struct packed {
		logic    ready;
		logic    setup;
		logic    rom_rd;
		logic    acc;
		logic    scale;
		logic    finish;
		mul_op_t mul_op;
	} ctl_t;

	typedef struct packed {
		logic sine;
		logic n_zero;
		logic last;
		logic out_free;
	} sts_t;

	typedef struct packed {
		logic [24:0] rec;
		logic [4:0]  sh;
	} recip_t;

	// quarter-wave sine entry, q1.15, evaluated at elaboration
	function automatic logic [14:0] quarter_sine(input int unsigned r, input int unsigned tbits);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned s;
		longint unsigned y;
		x = 64'(r) << (32 - tbits);
		x2 = (x * x) >> 30;
		s = SINC9;
		s = SINC7 - ((x2 * s) >> 30);
		s = SINC5 - ((x2 * s) >> 30);
		s = SINC3 - ((x2 * s) >> 30);
		s = SINC1 - ((x2 * s) >> 30);
		y = (x * s) >> 30;
		y = (y + 64'd16384) >> 15;
		if (y > 64'd32767)
			y = 64'd32767;
		return y[14:0];
	endfunction

endpackage

// ----- rtl/fwg_mul.sv -----
// shared unsigned 32x32 multiplier of the generator datapath
// depends on nothing; the product is registered by the caller
module fwg_mul (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p
);

	assign p = 64'(a) * 64'(b);

endmodule

// ----- rtl/fwg_sine_rom.sv -----
// sine lookup: quarter-wave constant table folded to a full turn, registered read
// depends on fwg_pkg for the table entry function
module fwg_sine_rom import fwg_pkg::*; #(
	parameter int SINE_TABLE_BITS = 10,
	localparam int A_W = SINE_TABLE_BITS - 1,
	localparam int QSIZE = 1 << (SINE_TABLE_BITS - 2)
) (
	input  logic        clk,
	input  logic        rd,
	input  logic [31:0] phase,
	output logic [14:0] mag,
	output logic        neg
);

	logic [14:0]                qtab [QSIZE+1];
	logic [SINE_TABLE_BITS-1:0] q;
	logic [1:0]                 quad;
	logic [A_W-1:0]             addr;
	logic [14:0]                mag_q;
	logic                       neg_q;

	for (genvar g = 0; g <= QSIZE; g++) begin : g_qtab
		localparam logic [14:0] V = quarter_sine(g, SINE_TABLE_BITS);
		assign qtab[g] = V;
	end

	always_comb begin
		q = phase[31 -: SINE_TABLE_BITS];
		quad = q[SINE_TABLE_BITS-1 -: 2];
		if (quad[0]) begin
			addr = A_W'(QSIZE) - {1'b0, q[SINE_TABLE_BITS-3:0]};
		end else begin
			addr = {1'b0, q[SINE_TABLE_BITS-3:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (rd) begin
			mag_q <= qtab[addr];
			neg_q <= quad[1];
		end
	end

	assign mag = mag_q;
	assign neg = neg_q;

endmodule

// ----- rtl/fwg_recip.sv -----
// reciprocal table per harmonic: divisor k, 2k-1 or (2k-1)^2 as multiplier and shift
// depends on fwg_pkg for the mode codes and the result type
module fwg_recip import fwg_pkg::*; #(
	parameter int MAX_HARMONICS = 64,
	localparam int KI_W = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1
) (
	input  logic [KI_W-1:0] k,
	input  mode_t           mode,
	output recip_t          rc
);

	logic [24:0] rs [MAX_HARMONICS];
	logic [24:0] rq [MAX_HARMONICS];
	logic [24:0] rt [MAX_HARMONICS];
	logic [4:0]  ls [MAX_HARMONICS];
	logic [4:0]  lq [MAX_HARMONICS];
	logic [4:0]  lt [MAX_HARMONICS];

	// round-up reciprocal, exact for dividends below 2^23
	for (genvar g = 0; g < MAX_HARMONICS; g++) begin : g_tab
		localparam longint unsigned DS = 64'(g) + 64'd1;
		localparam longint unsigned DQ = 64'(2 * g) + 64'd1;
		localparam longint unsigned DT = DQ * DQ;
		localparam int LS = $clog2(DS);
		localparam int LQ = $clog2(DQ);
		localparam int LT = $clog2(DT);
		localparam longint unsigned RS = ((64'd1 << (TERM_FRAC + LS)) + DS - 64'd1) / DS;
		localparam longint unsigned RQ = ((64'd1 << (TERM_FRAC + LQ)) + DQ - 64'd1) / DQ;
		localparam longint unsigned RT = ((64'd1 << (TERM_FRAC + LT)) + DT - 64'd1) / DT;
		assign rs[g] = 25'(RS);
		assign rq[g] = 25'(RQ);
		assign rt[g] = 25'(RT);
		assign ls[g] = 5'(LS);
		assign lq[g] = 5'(LQ);
		assign lt[g] = 5'(LT);
	end

	always_comb begin
		case (mode)
			MODE_SQUARE: begin
				rc.rec = rq[k];
				rc.sh = lq[k];
			end
			MODE_TRIANGLE: begin
				rc.rec = rt[k];
				rc.sh = lt[k];
			end
			default: begin
				rc.rec = rs[k];
				rc.sh = ls[k];
			end
		endcase
	end

endmodule

// ----- rtl/fwg_seq.sv -----
// sequencer of the generator: phase, per-harmonic lookup/multiply/accumulate, scaling
// depends on fwg_pkg for the state, control and status types
module fwg_seq import fwg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  sts_t sts,
	output ctl_t ctl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_PHASE;
			end
			ST_PHASE: state_d = ST_SETUP;
			ST_SETUP: begin
				state_d = (sts.sine || !sts.n_zero) ? ST_ROM : ST_COEF;
			end
			ST_ROM: state_d = ST_TERM;
			ST_TERM: begin
				state_d = sts.sine ? ST_DONE : ST_ACC;
			end
			ST_ACC: begin
				state_d = sts.last ? ST_COEF : ST_TERM;
			end
			ST_COEF: state_d = ST_SCALE;
			ST_SCALE: state_d = ST_AMP;
			ST_AMP: state_d = ST_DONE;
			ST_DONE: begin
				if (sts.out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		ctl.mul_op = MUL_NONE;
		case (state_q)
			ST_IDLE: ctl.ready = 1'b1;
			ST_PHASE: ctl.mul_op = MUL_PHASE;
			ST_SETUP: ctl.setup = 1'b1;
			ST_ROM: ctl.rom_rd = 1'b1;
			ST_TERM: ctl.mul_op = MUL_TERM;
			ST_ACC: begin
				ctl.acc = 1'b1;
				ctl.rom_rd = !sts.last;
			end
			ST_COEF: ctl.mul_op = MUL_COEF;
			ST_SCALE: ctl.scale = 1'b1;
			ST_AMP: ctl.mul_op = MUL_AMP;
			ST_DONE: ctl.finish = sts.out_free;
			default: ctl.ready = 1'b0;
		endcase
	end

endmodule

// ----- rtl/fourier_waveform_generator.sv -----
// top level of the fourier waveform generator: registers, datapath and output stage
// depends on fwg_pkg, fwg_mul, fwg_sine_rom, fwg_recip and fwg_seq
//
// usage:
// - configuration: cfg_we/cfg_index/cfg_data write wave mode, amplitude, phase step,
//   harmonic count and sine phase offset; write only while no item is in flight
// - input: one item on s_tvalid/s_tready carries a sample index; s_tready is high
//   while the sequencer waits for work, low while an item is computed
// - output: one item per input on m_tvalid/m_tready with the saturated sample and
//   the original index; the output register holds it until taken
// - steps from accept to result: in sine mode the phase multiply, setup, sine lookup
//   and amplitude multiply; in the series modes with n harmonics the phase multiply,
//   setup, harmonic loop (skipped when n is zero), coefficient, scale and amplitude
//   steps; the next item can be taken in the cycle after the result is loaded
// - pace: the harmonic loop sets it in the series modes, where one shared multiplier
//   scales each sine lookup by its reciprocal and the next cycle adds it
// - reset clears the registers to their defaults and empties the output stage
// - a stalled receiver holds the result; a new item may be taken meanwhile, and its
//   result waits in the last step until the output register is free
module fourier_waveform_generator import fwg_pkg::*; #(
	parameter int MAX_HARMONICS = 64,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // sample_index
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // sample_index_out, sample_value
);

	localparam int K_W = $clog2(MAX_HARMONICS + 1);
	localparam int KI_W = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
	localparam int SUM_W = 24 + K_W;

	mode_t        wave_mode_q;
	logic [14:0]  amplitude_q;
	logic [31:0]  phase_step_q;
	logic [6:0]   harmonic_count_q;
	logic [31:0]  sine_offset_q;

	ctl_t         ctl;
	sts_t         sts;
	logic         accept;

	logic [15:0]  idx_q;
	logic [15:0]  pos;
	logic [K_W-1:0] n_q;
	logic [K_W-1:0] n_clamp;
	logic [K_W-1:0] k_q;
	logic [31:0]  ph_q;
	logic [31:0]  step_q;
	logic [63:0]  prod_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] sum_abs;
	logic signed [SUM_W-1:0] term_s;
	recip_t       recip_q;
	recip_t       recip_d;
	logic         tsub_q;
	logic         tneg_q;
	logic         sgn_q;
	logic [31:0]  val_q;

	logic [14:0]  rom_mag;
	logic         rom_neg;
	logic [31:0]  mul_a;
	logic [31:0]  mul_b;
	logic [63:0]  mul_p;
	logic [31:0]  coef;
	logic [63:0]  term_mag;
	logic [33:0]  rmag;
	logic signed [35:0] r_s;
	logic signed [35:0] diff;
	logic signed [35:0] diff_abs;
	logic [63:0]  vmag;
	logic [15:0]  value;

	logic         m_tvalid_q;
	logic [31:0]  m_tdata_q;

	assign accept = s_tvalid && s_tready;
	assign s_tready = ctl.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_mode_q <= MODE_SINE;
			amplitude_q <= AMPLITUDE_RESET;
			phase_step_q <= '0;
			harmonic_count_q <= HARMONIC_RESET;
			sine_offset_q <= '0;
		end else if (cfg_we) begin
			case (reg_t'(cfg_index))
				REG_WAVE_MODE: wave_mode_q <= mode_t'(cfg_data[1:0]);
				REG_AMPLITUDE: amplitude_q <= cfg_data[14:0];
				REG_PHASE_STEP: phase_step_q <= cfg_data;
				REG_HARMONIC_COUNT: harmonic_count_q <= cfg_data[6:0];
				REG_PHASE_OFFSET: sine_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	fwg_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.sts      (sts),
		.ctl      (ctl)
	);

	assign sts.sine = (wave_mode_q == MODE_SINE);
	assign sts.n_zero = (n_q == '0);
	assign sts.last = (k_q == n_q);
	assign sts.out_free = !m_tvalid_q || m_tready;

	fwg_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_rom (
		.clk   (clk),
		.rd    (ctl.rom_rd),
		.phase (ph_q),
		.mag   (rom_mag),
		.neg   (rom_neg)
	);

	fwg_recip #(.MAX_HARMONICS(MAX_HARMONICS)) u_recip (
		.k    (k_q[KI_W-1:0]),
		.mode (wave_mode_q),
		.rc   (recip_d)
	);

	fwg_mul u_mul (
		.a (mul_a),
		.b (mul_b),
		.p (mul_p)
	);

	assign pos = 16'(32'(idx_q) % BUFFER_LEN);
	assign n_clamp = (32'(harmonic_count_q) > MAX_HARMONICS) ? K_W'(MAX_HARMONICS)
		: K_W'(harmonic_count_q);
	assign sum_abs = sum_q[SUM_W-1] ? -sum_q : sum_q;

	always_comb begin
		case (wave_mode_q)
			MODE_SAW: coef = COEF_INV_PI;
			MODE_SQUARE: coef = COEF_FOUR_PI;
			default: coef = COEF_INV_PI2;
		endcase
	end

	always_comb begin
		case (ctl.mul_op)
			MUL_PHASE: begin
				mul_a = 32'(pos);
				mul_b = phase_step_q;
			end
			MUL_TERM: begin
				if (sts.sine) begin
					mul_a = 32'(rom_mag);
					mul_b = 32'(amplitude_q);
				end else begin
					mul_a = 32'({rom_mag, 8'd0});
					mul_b = 32'(recip_q.rec);
				end
			end
			MUL_COEF: begin
				mul_a = 32'($unsigned(sum_abs));
				mul_b = coef;
			end
			MUL_AMP: begin
				mul_a = val_q;
				mul_b = 32'(amplitude_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		term_mag = prod_q >> (6'(TERM_FRAC) + 6'(recip_q.sh));
		term_s = signed'(SUM_W'(term_mag[23:0]));
		rmag = prod_q[63:COEF_FRAC];
		r_s = sgn_q ? -signed'({2'b00, rmag}) : signed'({2'b00, rmag});
		diff = 36'(Q23_HALF) - r_s;
		diff_abs = diff[35] ? -diff : diff;
		vmag = prod_q >> (sts.sine ? SINE_FRAC : TERM_FRAC);
		if (sgn_q) begin
			value = (vmag > 64'd32768) ? 16'h8000 : 16'(64'd0 - vmag);
		end else begin
			value = (vmag > 64'd32767) ? 16'h7fff : vmag[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			k_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept)
				n_q <= n_clamp;
			if (ctl.setup) begin
				k_q <= '0;
			end else if (ctl.rom_rd) begin
				k_q <= k_q + 1'b1;
			end
			if (ctl.finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			idx_q <= s_tdata;
		if (ctl.mul_op != MUL_NONE)
			prod_q <= mul_p;
		if (ctl.setup) begin
			ph_q <= sts.sine ? prod_q[31:0] + sine_offset_q : prod_q[31:0];
			step_q <= (wave_mode_q == MODE_SAW) ? prod_q[31:0] : {prod_q[30:0], 1'b0};
			sum_q <= '0;
		end
		if (ctl.rom_rd) begin
			ph_q <= ph_q + step_q;
			recip_q <= recip_d;
			tsub_q <= (wave_mode_q == MODE_TRIANGLE) && k_q[0];
		end
		if (ctl.mul_op == MUL_TERM) begin
			tneg_q <= rom_neg ^ tsub_q;
			sgn_q <= rom_neg;
		end
		if (ctl.acc)
			sum_q <= tneg_q ? sum_q - term_s : sum_q + term_s;
		if (ctl.mul_op == MUL_COEF)
			sgn_q <= sum_q[SUM_W-1];
		if (ctl.scale) begin
			if (wave_mode_q == MODE_SAW) begin
				val_q <= diff_abs[31:0];
				sgn_q <= diff[35];
			end else begin
				val_q <= rmag[31:0];
			end
		end
		if (ctl.finish)
			m_tdata_q <= {idx_q, value};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

`ifndef NO_ASSERTIONS
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.acc |-> k_q <= n_q)
		else $error("harmonic counter ran past the harmonic count");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input still ready after an item was taken");
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(ctl.finish))
		else $error("output valid without a finished item");
	a_acc_has_term: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.acc |-> (k_q != '0) && $past(ctl.mul_op == MUL_TERM))
		else $error("accumulate without a scaled term");
`endif

endmodule

// ----- bench/fwg_sample_check.sv -----
// sample checker for the fourier waveform generator: mirrors the registers, predicts each
// sample from its index and compares every output item; depends on fwg_pkg
module fwg_sample_check import fwg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // sample_index
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // sample_index_out, sample_value
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HARMONIC_LIMIT = 64;
	localparam longint unsigned POLY_C1 = 64'd1686629713;
	localparam longint unsigned POLY_C3 = 64'd693598668;
	localparam longint unsigned POLY_C5 = 64'd85569306;
	localparam longint unsigned POLY_C7 = 64'd5026995;
	localparam longint unsigned POLY_C9 = 64'd172272;
	localparam longint GAIN_INV_PI = 64'sd341782638;
	localparam longint GAIN_FOUR_PI = 64'sd1367130551;
	localparam longint GAIN_INV_PI2 = 64'sd108792793;
	localparam longint ONE_Q30 = 64'sd1073741824;
	localparam longint HALF_Q23 = 64'sd4194304;
	localparam longint ONE_Q23 = 64'sd8388608;

	typedef struct packed {
		logic [15:0] index;
		logic [15:0] value;
	} sample_t;

	mode_t       wave_mode;
	logic [14:0] amplitude;
	logic [31:0] phase_step;
	logic [6:0]  harmonics;
	logic [31:0] sine_offset;
	sample_t     pending_samples[$];
	int          err_count = 0;

	assign mismatches = err_count;

	// q1.15 sine from the top ten phase bits, quarter wave mirrored
	function automatic longint sine_q15(input logic [31:0] ph);
		logic [1:0]      quad;
		int unsigned     r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned s;
		longint unsigned y;
		quad = ph[31:30];
		r = ph[29:22];
		if (quad[0])
			r = 256 - r;
		x = 64'(r) << 22;
		x2 = (x * x) >> 30;
		s = POLY_C9;
		s = POLY_C7 - ((x2 * s) >> 30);
		s = POLY_C5 - ((x2 * s) >> 30);
		s = POLY_C3 - ((x2 * s) >> 30);
		s = POLY_C1 - ((x2 * s) >> 30);
		y = (x * s) >> 30;
		y = (y + 64'd16384) >> 15;
		if (y > 64'd32767)
			y = 64'd32767;
		return quad[1] ? -longint'(y) : longint'(y);
	endfunction

	function automatic logic [15:0] synth_sample(input logic [15:0] idx);
		logic [31:0] phase;
		logic [31:0] ph;
		int          n;
		int          m;
		longint      a;
		longint      sum;
		longint      term;
		longint      r;
		longint      v;
		phase = 32'(idx) * phase_step;
		n = (harmonics > HARMONIC_LIMIT) ? HARMONIC_LIMIT : int'(harmonics);
		a = longint'(amplitude);
		sum = 0;
		v = 0;
		case (wave_mode)
			MODE_SINE: begin
				v = a * sine_q15(phase + sine_offset) / 32768;
			end
			MODE_SAW: begin
				for (int k = 1; k <= n; k++) begin
					ph = 32'(k) * phase;
					sum += sine_q15(ph) * 256 / longint'(k);
				end
				r = GAIN_INV_PI * sum / ONE_Q30;
				v = a * (HALF_Q23 - r) / ONE_Q23;
			end
			MODE_SQUARE: begin
				for (int k = 1; k <= n; k++) begin
					m = 2 * k - 1;
					ph = 32'(m) * phase;
					sum += sine_q15(ph) * 256 / longint'(m);
				end
				r = GAIN_FOUR_PI * sum / ONE_Q30;
				v = a * r / ONE_Q23;
			end
			default: begin
				for (int k = 0; k < n; k++) begin
					m = 2 * k + 1;
					ph = 32'(m) * phase;
					term = sine_q15(ph) * 256 / longint'(m * m);
					sum = k[0] ? sum - term : sum + term;
				end
				r = GAIN_INV_PI2 * sum / ONE_Q30;
				v = a * r / ONE_Q23;
			end
		endcase
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sample_t got;
		sample_t want;
		if (!arst_n) begin
			wave_mode = MODE_SINE;
			amplitude = 15'd16384;
			phase_step = '0;
			harmonics = 7'd16;
			sine_offset = '0;
			pending_samples.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (reg_t'(cfg_index))
					REG_WAVE_MODE:      wave_mode = mode_t'(cfg_data[1:0]);
					REG_AMPLITUDE:      amplitude = cfg_data[14:0];
					REG_PHASE_STEP:     phase_step = cfg_data;
					REG_HARMONIC_COUNT: harmonics = cfg_data[6:0];
					REG_PHASE_OFFSET:   sine_offset = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (pending_samples.size() == 0) begin
					$error("unexpected sample, value %0d index %0d",
						$signed(got.value), got.index);
					err_count++;
				end else begin
					want = pending_samples.pop_front();
					if (got.value !== want.value) begin
						$error("sample_value: expected %0d, got %0d",
							$signed(want.value), $signed(got.value));
						err_count++;
					end
					if (got.index !== want.index) begin
						$error("sample_index_out: expected %0d, got %0d",
							want.index, got.index);
						err_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				want.value = synth_sample(s_tdata);
				want.index = s_tdata;
				pending_samples = {pending_samples, want};
			end
			outstanding <= pending_samples.size();
		end
	end

endmodule

// ----- bench/tb_fourier_waveform_generator.sv -----
// testbench top for the fourier waveform generator: clock, reset, register writes,
// index stimulus and output back-pressure; depends on fwg_pkg, fourier_waveform_generator and fwg_sample_check
module tb_fourier_waveform_generator import fwg_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 200;
	localparam int RANDOM_ITEMS = 750;
	localparam logic [2:0] REG_SPARE = 3'd5;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_WAVE_MODE;
	logic [31:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        rx_steady = 1'b0;
	int          mismatches;
	int          outstanding;
	int          cycle_count = 0;

	fourier_waveform_generator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	fwg_sample_check sample_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int pause_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 93)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [15:0] pick_index();
		int p;
		p = $urandom_range(0, 99);
		if (p < 5)
			return 16'h0000;
		if (p < 10)
			return 16'hFFFF;
		return 16'($urandom());
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h0000_0001;
			3: return $urandom() >> $urandom_range(8, 24);
			default: return $urandom();
		endcase
	endfunction

	// receiver back-pressure
	initial begin
		int run;
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (rx_steady) begin
				m_tready <= 1'b1;
				@(negedge clk);
			end else begin
				run = $urandom_range(1, 12);
				m_tready <= 1'b1;
				repeat (run) @(negedge clk);
				gap = pause_len();
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
		end
	end

	// called at a falling edge; cfg_we stays high until the batch is done
	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
	endtask

	// unused register bits carry junk
	task automatic set_config(input mode_t mode, input logic [14:0] amp,
		input logic [31:0] step, input logic [6:0] count, input logic [31:0] offset);
		cfg_write(REG_WAVE_MODE, ($urandom() & ~32'h3) | 32'(mode));
		cfg_write(REG_AMPLITUDE, ($urandom() & ~32'h7FFF) | 32'(amp));
		cfg_write(REG_PHASE_STEP, step);
		cfg_write(REG_HARMONIC_COUNT, ($urandom() & ~32'h7F) | 32'(count));
		cfg_write(REG_PHASE_OFFSET, offset);
		if ($urandom_range(0, 3) == 0)
			cfg_write(REG_SPARE + 3'($urandom_range(0, 2)), $urandom());
		cfg_we <= 1'b0;
	endtask

	task automatic send(input logic [15:0] idx, input int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= idx;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic finish_batch();
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	initial begin
		int          sent;
		int          batch;
		bit          burst;
		mode_t       mode;
		logic [14:0] amp;
		logic [6:0]  count;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset defaults
		send(16'h0000, 0);
		send(16'hFFFF, 0);
		finish_batch();

		// sine at full scale with a three-quarter-turn offset
		set_config(MODE_SINE, 15'd32767, 32'h0040_0000, 7'd16, 32'hC000_0000);
		send(16'd0, 0);
		send(16'd1, 0);
		send(16'd255, 0);
		send(16'd256, 0);
		send(16'hFFFF, 0);
		finish_batch();

		// empty series
		set_config(MODE_SAW, 15'd32767, 32'h1000_0000, 7'd0, 32'h0000_0000);
		send(16'd3, 0);
		finish_batch();

		// count above the harmonic limit
		set_config(MODE_SAW, 15'd32767, 32'h1000_0000, 7'd127, 32'hFFFF_FFFF);
		send(16'd0, 0);
		send(16'd1, 0);
		send(16'd9, 0);
		finish_batch();

		// gibbs overshoot near the edges, saturating
		set_config(MODE_SQUARE, 15'd32767, 32'h0080_0000, 7'd64, 32'h0000_0000);
		send(16'd1, 0);
		send(16'd2, 0);
		send(16'd64, 0);
		send(16'hFFFF, 0);
		finish_batch();

		set_config(MODE_SQUARE, 15'd0, 32'hFFFF_FFFF, 7'd0, 32'h0000_0000);
		send(16'd1, 0);
		finish_batch();

		set_config(MODE_TRIANGLE, 15'd32767, 32'h4000_0000, 7'd1, 32'h0000_0000);
		send(16'd1, 0);
		send(16'd3, 0);
		finish_batch();

		set_config(MODE_TRIANGLE, 15'd1, 32'h0123_4567, 7'd64, 32'h0000_0000);
		send(16'hFFFF, 0);
		finish_batch();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mode = mode_t'($urandom_range(0, 3));
			case ($urandom_range(0, 3))
				0: amp = 15'd0;
				1: amp = 15'd32767;
				default: amp = 15'($urandom());
			endcase
			case ($urandom_range(0, 9))
				0: count = 7'd0;
				1: count = 7'd64;
				2: count = 7'd127;
				3: count = 7'($urandom());
				4: count = 7'($urandom_range(9, 63));
				default: count = 7'($urandom_range(1, 8));
			endcase
			set_config(mode, amp, pick_word(), count, pick_word());
			rx_steady <= ($urandom_range(0, 3) == 0);
			burst = ($urandom_range(0, 3) == 0);
			batch = $urandom_range(8, 40);
			repeat (batch) begin
				send(pick_index(), burst ? 0 : pause_len());
				sent++;
			end
			finish_batch();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/fwg_pkg.sv
rtl/fwg_mul.sv
rtl/fwg_sine_rom.sv
rtl/fwg_recip.sv
rtl/fwg_seq.sv
rtl/fourier_waveform_generator.sv
bench/fwg_sample_check.sv
bench/tb_fourier_waveform_generator.sv
